>>> src/demand_paging_translator_unit_macros.svh
// Assertion macros shared by the translator RTL.
// Each macro expects clk and arst_n in the enclosing module.
`ifndef DEMAND_PAGING_TRANSLATOR_UNIT_MACROS_SVH
`define DEMAND_PAGING_TRANSLATOR_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define DPT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define DPT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/dpt_pkg.sv
// Shared types and codes of the demand paging translator.
// No dependencies; imported by every module of the block.
package dpt_pkg;

	localparam int CFG_IDX_W = 8;
	localparam int PAGES_W   = 5;
	localparam int REG_COUNT = 4;

	localparam logic [CFG_IDX_W-1:0] REG_PAGES_SLOT0 = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAGES_SLOT1 = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAGES_SLOT2 = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PAGES_SLOT3 = 8'd3;

	localparam logic [1:0] ST_HIT     = 2'd0;
	localparam logic [1:0] ST_SERVED  = 2'd1;
	localparam logic [1:0] ST_RANGE   = 2'd2;
	localparam logic [1:0] ST_NOFRAME = 2'd3;

	typedef struct packed {
		logic [1:0] process_slot;
		logic [7:0] vaddr;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [5:0]  frame_index;
		logic [7:0]  paddr;
		logic [31:0] fault_total;
		logic [31:0] hit_total;
	} rsp_t;

	// decoded access: range check result and page offset
	typedef struct packed {
		logic       in_range;
		logic [7:0] offset;
	} split_t;

endpackage

>>> src/dpt_split.sv
// Address split and range check for one access.
// Depends on dpt_pkg; page and offset come from elaboration-time tables.
module dpt_split #(
	parameter int PAGE_UNITS     = 4,
	parameter int PAGES_PER_SLOT = 16,
	parameter int SLOT_COUNT     = 4,
	parameter int IDX_W          = 6
) (
	input  dpt_pkg::req_t             req,
	input  logic [4:0]                pages,
	output dpt_pkg::split_t           info,
	output logic [IDX_W-1:0]          index
);
	import dpt_pkg::*;

	logic [7:0]  page_tbl [256];
	logic [7:0]  off_tbl [256];
	logic [7:0]  page;
	logic [8:0]  limit;
	logic        slot_ok;
	logic [12:0] idx_wide;

	for (genvar i = 0; i < 256; i++) begin : g_div
		assign page_tbl[i] = 8'(i / PAGE_UNITS);
		assign off_tbl[i]  = 8'(i % PAGE_UNITS);
	end

	always_comb begin
		page = page_tbl[req.vaddr];
		info.offset = off_tbl[req.vaddr];
		// clamp the configured count to the table size
		if ({4'b0, pages} > 9'(PAGES_PER_SLOT))
			limit = 9'(PAGES_PER_SLOT);
		else
			limit = {4'b0, pages};
		slot_ok = ({3'b0, req.process_slot} < 5'(SLOT_COUNT));
		info.in_range = slot_ok && ({1'b0, page} < limit);
		idx_wide = 13'(req.process_slot) * 13'(PAGES_PER_SLOT) + 13'(page);
		index = idx_wide[IDX_W-1:0];
	end

endmodule

>>> src/dpt_ptab.sv
// Page table memory: one entry per page, {present, frame}.
// Depends on dpt_pkg; runs a clearing sweep after reset.
module dpt_ptab #(
	parameter int DEPTH = 64,
	parameter int IDX_W = 6,
	parameter int WIDTH = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_addr,
	output logic [WIDTH-1:0] rd_data,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	output logic             clearing
);
	import dpt_pkg::*;

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;
	logic [IDX_W-1:0] clr_idx_q;
	logic             clearing_q;
	logic             we;
	logic [IDX_W-1:0] wa;
	logic [WIDTH-1:0] wd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clearing_q) begin
			if (clr_idx_q == IDX_W'(DEPTH - 1))
				clearing_q <= 1'b0;
			else
				clr_idx_q <= clr_idx_q + 1'b1;
		end
	end

	always_comb begin
		we = clearing_q || wr_en;
		wa = clearing_q ? clr_idx_q : wr_addr;
		wd = clearing_q ? '0 : wr_data;
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[wa] <= wd;
		if (rd_en)
			rd_data_q <= mem[rd_addr];
	end

	assign rd_data  = rd_data_q;
	assign clearing = clearing_q;

endmodule

>>> src/demand_paging_translator_unit.sv
// Demand paging translator, top level.
// Depends on dpt_pkg, dpt_split, dpt_ptab and the assertion macro header.
//
// Channels: req (process_slot, virtual address) in, rsp (status, frame,
// physical address, fault and hit totals) out, both valid/stall; the
// receiver drives stall. cfg is a valid/ready write port (always ready)
// for the four per-slot page counts; unknown indexes are ignored.
// Each access yields exactly one rsp beat, in order.
// Timing: an accepted beat reads the page table into a register; in the
// lookup stage the entry is checked, written back on a served fault, and the
// rsp beat is registered. The next req beat is taken only once the lookup
// stage has emptied; the read-then-write-back of the page table sets that.
// Free frames are handed out in order by a fill counter.
// Reset: counters, frame counter and page counts clear; the page table is
// swept clear, one entry a cycle, SLOT_COUNT*PAGES_PER_SLOT entries (64 by
// default), with req stalled meanwhile; cfg writes are taken throughout.
// Stall on rsp: the finished beat holds; one more req beat is accepted and
// waits in the lookup stage until the rsp register frees.
`include "demand_paging_translator_unit_macros.svh"
module demand_paging_translator_unit #(
	parameter int FRAME_COUNT    = 64,
	parameter int PAGE_UNITS     = 4,
	parameter int PAGES_PER_SLOT = 16,
	parameter int SLOT_COUNT     = 4
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 req_valid,
	output logic                                 req_stall,
	input  dpt_pkg::req_t                        req,
	output logic                                 rsp_valid,
	input  logic                                 rsp_stall,
	output dpt_pkg::rsp_t                        rsp,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [dpt_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [dpt_pkg::PAGES_W-1:0]          cfg_data
);
	import dpt_pkg::*;

	localparam int TABLE_SIZE = SLOT_COUNT * PAGES_PER_SLOT;
	localparam int IDX_W      = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
	localparam int FW         = $clog2(FRAME_COUNT);
	localparam int NF_W       = $clog2(FRAME_COUNT + 1);
	localparam int ENTRY_W    = FW + 1;

	logic [PAGES_W-1:0] pages_q [REG_COUNT];
	logic [31:0]        fault_q;
	logic [31:0]        hit_q;
	logic [NF_W-1:0]    next_frame_q;

	split_t             split_in;
	logic [IDX_W-1:0]   idx_in;
	logic               valid_s1;
	split_t             split_s1;
	logic [IDX_W-1:0]   idx_s1;

	logic               rsp_valid_q;
	rsp_t               rsp_q;

	logic               clearing;
	logic [ENTRY_W-1:0] rd_data;
	logic               accept;
	logic               complete;
	logic               present;
	logic               hit;
	logic               miss;
	logic               serve;
	logic [FW-1:0]      frame_sel;
	logic [31:0]        frame_w;
	logic [31:0]        pa_w;
	logic [31:0]        fault_next;
	logic [31:0]        hit_next;
	rsp_t               rsp_next;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REG_COUNT; i++)
				pages_q[i] <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_PAGES_SLOT0: pages_q[0] <= cfg_data;
				REG_PAGES_SLOT1: pages_q[1] <= cfg_data;
				REG_PAGES_SLOT2: pages_q[2] <= cfg_data;
				REG_PAGES_SLOT3: pages_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	dpt_split #(
		.PAGE_UNITS     (PAGE_UNITS),
		.PAGES_PER_SLOT (PAGES_PER_SLOT),
		.SLOT_COUNT     (SLOT_COUNT),
		.IDX_W          (IDX_W)
	) u_split (
		.req   (req),
		.pages (pages_q[req.process_slot]),
		.info  (split_in),
		.index (idx_in)
	);

	// one item in the lookup stage at a time, so read and write-back never overlap
	assign req_stall = clearing || valid_s1;
	assign accept    = req_valid && !req_stall;
	assign complete  = valid_s1 && (!rsp_valid_q || !rsp_stall);

	dpt_ptab #(
		.DEPTH (TABLE_SIZE),
		.IDX_W (IDX_W),
		.WIDTH (ENTRY_W)
	) u_ptab (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_addr  (idx_in),
		.rd_data  (rd_data),
		.wr_en    (complete && serve),
		.wr_addr  (idx_s1),
		.wr_data  ({1'b1, frame_sel}),
		.clearing (clearing)
	);

	always_comb begin
		present   = rd_data[FW];
		hit       = split_s1.in_range && present;
		miss      = split_s1.in_range && !present;
		serve     = miss && (next_frame_q != NF_W'(FRAME_COUNT));
		frame_sel = hit ? rd_data[FW-1:0] : next_frame_q[FW-1:0];
		frame_w   = 32'(frame_sel);
		pa_w      = frame_w * 32'(PAGE_UNITS) + {24'b0, split_s1.offset};
		fault_next = fault_q + {31'b0, miss};
		hit_next   = hit_q + {31'b0, hit};

		rsp_next.fault_total = fault_next;
		rsp_next.hit_total   = hit_next;
		if (hit || serve) begin
			rsp_next.status      = hit ? ST_HIT : ST_SERVED;
			rsp_next.frame_index = frame_w[5:0];
			rsp_next.paddr       = pa_w[7:0];
		end else begin
			rsp_next.status      = split_s1.in_range ? ST_NOFRAME : ST_RANGE;
			rsp_next.frame_index = '0;
			rsp_next.paddr       = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			rsp_valid_q  <= 1'b0;
			fault_q      <= '0;
			hit_q        <= '0;
			next_frame_q <= '0;
		end else begin
			if (accept)
				valid_s1 <= 1'b1;
			else if (complete)
				valid_s1 <= 1'b0;

			if (complete) begin
				rsp_valid_q <= 1'b1;
				fault_q     <= fault_next;
				hit_q       <= hit_next;
				if (serve)
					next_frame_q <= next_frame_q + 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			split_s1 <= split_in;
			idx_s1   <= idx_in;
		end
		if (complete)
			rsp_q <= rsp_next;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`DPT_ASSERT_NOW(a_frame_bound, 1'b1, next_frame_q <= NF_W'(FRAME_COUNT), "frame counter overran")
	`DPT_ASSERT_NOW(a_hit_frame_alloc, valid_s1 && hit, NF_W'(frame_sel) < next_frame_q,
		"hit on unallocated frame")
	`DPT_ASSERT_NEXT(a_serve_counts, complete && serve, fault_q == $past(fault_q) + 32'd1,
		"served fault not counted")
	`DPT_ASSERT_NOW(a_fail_zero,
		rsp_valid && (rsp.status == ST_RANGE || rsp.status == ST_NOFRAME),
		rsp.frame_index == 6'd0 && rsp.paddr == 8'd0, "failed access carries a frame")

endmodule
